// File: hdl/audio_queue_playback_cursor_defines.svh
// Assertion macros shared by the playback cursor RTL.
// Depends on nothing; expects clk and rst_n in the including scope.
`ifndef AUDIO_QUEUE_PLAYBACK_CURSOR_DEFINES_SVH
`define AUDIO_QUEUE_PLAYBACK_CURSOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define AQPC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define AQPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/aqpc_pkg.sv
// Package of the audio queue playback cursor: field widths, codes, states.
// Depends on nothing; every file but the defines header uses it by scoped names.
package aqpc_pkg;

  localparam int RATE_W = 19;
  localparam int SECS_W = 4;
  localparam int NSEC_W = 30;
  localparam int TGT_W  = 26;
  localparam int Q_W    = 24;
  localparam int ADV_W  = 23;
  localparam int OFF_W  = 24;
  localparam int POS_W  = 26;
  localparam int FRAC_W = 31;
  localparam int STAT_W = 2;
  localparam int OP_W   = 2;
  localparam int IDX_W  = 2;
  localparam int BCNT_W = 3;

  localparam logic [NSEC_W-1:0] NS_PER_S    = 30'd1000000000;
  localparam logic [31:0]       TWO_NS      = 32'd2000000000;
  localparam logic signed [31:0] HALF_NS    = 32'sd500000000;
  localparam logic signed [31:0] NS_PER_S_S = 32'sd1000000000;
  localparam logic [Q_W-1:0]    COUNT_MAX   = 24'd8388607;

  localparam logic [OP_W-1:0] OP_ADVANCE = 2'd0;
  localparam logic [OP_W-1:0] OP_SEEK    = 2'd1;
  localparam logic [OP_W-1:0] OP_PLAY    = 2'd2;

  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_IGNORED = 2'd1;
  localparam logic [STAT_W-1:0] ST_END     = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE   = 2'd3;

  localparam logic [2:0] REG_SAMPLE_RATE = 3'd0;
  localparam logic [2:0] REG_LOOP        = 3'd1;
  localparam logic [2:0] REG_BCOUNT      = 3'd2;
  localparam logic [2:0] REG_SIZE_A      = 3'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_SCALE, S_ROUND, S_SAT, S_AVAIL, S_WALK, S_TOT, S_MOD,
    S_SCAN, S_POS_INIT, S_POS, S_OUT
  } state_t;

endpackage

// File: hdl/aqpc_if.sv
// Request and result channel interfaces of the playback cursor.
// Depends on aqpc_pkg for the field widths.
interface aqpc_in_if;
  logic                         valid;
  logic                         ready;
  logic [aqpc_pkg::OP_W-1:0]    op;
  logic [aqpc_pkg::SECS_W-1:0]  elapsed_seconds;
  logic [aqpc_pkg::NSEC_W-1:0]  elapsed_nanoseconds;
  logic [aqpc_pkg::TGT_W-1:0]   seek_target;
  modport source (output valid, op, elapsed_seconds, elapsed_nanoseconds, seek_target,
                  input ready);
  modport sink (input valid, op, elapsed_seconds, elapsed_nanoseconds, seek_target,
                output ready);
endinterface

interface aqpc_out_if;
  logic                         valid;
  logic                         ready;
  logic [aqpc_pkg::STAT_W-1:0]  status;
  logic [aqpc_pkg::ADV_W-1:0]   samples_advanced;
  logic [aqpc_pkg::IDX_W-1:0]   buffer_index;
  logic [aqpc_pkg::OFF_W-1:0]   buffer_offset;
  logic [aqpc_pkg::POS_W-1:0]   total_position;
  logic                         playing;
  modport source (output valid, status, samples_advanced, buffer_index, buffer_offset,
                  total_position, playing, input ready);
  modport sink (input valid, status, samples_advanced, buffer_index, buffer_offset,
                total_position, playing, output ready);
endinterface

// File: hdl/audio_queue_playback_cursor.sv
// Top level of the audio queue playback cursor: config registers, sequencer.
// Depends on aqpc_pkg, aqpc_if, aqpc_scale, aqpc_rem and the defines header.
//
//   channel   direction  handshake           carries
//   in_req    in         valid/ready         op, elapsed time, seek target
//   out_rsp   out        valid/ready         status, count, cursor, position
//   config    in         APB psel/penable    sample rate, loop, count, sizes
//
// An advance spends most of its time in the serial time to sample loop, and
// a wrapping walk adds the remainder unit; a seek with looping uses it too.
// Reset is synchronous and active low and returns the configuration, cursor
// and control registers to their defaults; work and result data registers
// are not reset. A new request is taken once the previous result is
// registered.
`include "audio_queue_playback_cursor_defines.svh"

module audio_queue_playback_cursor #(
  parameter int QUEUE_DEPTH = 4,
  parameter int OFFSET_BITS = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  aqpc_in_if.sink             in_req,
  aqpc_out_if.source          out_rsp,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // Stored sizes keep only the bits that the offset can address.
  localparam int SizeW = (OFFSET_BITS < 24) ? OFFSET_BITS : 24;

  // Configuration registers.
  logic [aqpc_pkg::RATE_W-1:0] rate_r;
  logic                        loop_r;
  logic [aqpc_pkg::BCNT_W-1:0] bcnt_r;
  logic [SizeW-1:0]            size_r [QUEUE_DEPTH];

  // Cursor state.
  aqpc_pkg::state_t state_r, state_nxt;
  logic playing_r, playing_nxt;
  logic [aqpc_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic [aqpc_pkg::OFF_W-1:0] off_r, off_nxt;
  logic signed [aqpc_pkg::FRAC_W-1:0] frac_r, frac_nxt;

  // Work registers of the request in flight.
  logic [aqpc_pkg::OP_W-1:0]   op_r, op_nxt;
  logic [aqpc_pkg::STAT_W-1:0] status_r, status_nxt;
  logic [aqpc_pkg::ADV_W-1:0]  adv_r, adv_nxt;
  logic [aqpc_pkg::Q_W-1:0]    n_r, n_nxt;
  logic signed [31:0]          rsum_r, rsum_nxt;
  logic [aqpc_pkg::OFF_W-1:0]  avail_r, avail_nxt;
  logic [aqpc_pkg::POS_W-1:0]  rest_r, rest_nxt, acc_r, acc_nxt;
  logic [aqpc_pkg::IDX_W-1:0]  scan_i_r, scan_i_nxt;
  logic [2:0]                  steps_r, steps_nxt;

  // Result register.
  logic out_valid_r, out_valid_nxt;
  logic [aqpc_pkg::STAT_W-1:0] o_status_r;
  logic [aqpc_pkg::ADV_W-1:0]  o_adv_r;
  logic [aqpc_pkg::IDX_W-1:0]  o_idx_r;
  logic [aqpc_pkg::OFF_W-1:0]  o_off_r;
  logic [aqpc_pkg::POS_W-1:0]  o_pos_r;
  logic                        o_play_r;
  logic                        out_load;

  // Helper units.
  logic scale_start, scale_done, rem_start, rem_done;
  logic [aqpc_pkg::Q_W-1:0]    scale_quo;
  logic [aqpc_pkg::NSEC_W-1:0] scale_rem;
  logic [aqpc_pkg::POS_W-1:0]  rem_dvd, rem_q;

  // Shared decode.
  logic                       in_acc, cfg_wr;
  logic [2:0]                 cfg_idx, cnt_eff, idx_inc, wrap_i, next_i, walk_steps, pos_steps;
  logic [aqpc_pkg::IDX_W-1:0] rd_i;
  logic [aqpc_pkg::OFF_W-1:0] sel_size;
  logic                       scan_hit, wraps;

  function automatic logic [2:0] wrap_mod(input logic [2:0] v, input logic [2:0] c);
    logic [2:0] x;
    x = v;
    for (int k = 0; k < 4; k++) begin
      if (x >= c) x = x - c;
    end
    return x;
  endfunction

  // APB port: writes land on the access phase, reads are always ready.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= aqpc_pkg::RATE_W'(44100);
      loop_r <= 1'b0;
      bcnt_r <= '0;
      for (int j = 0; j < QUEUE_DEPTH; j++) size_r[j] <= '0;
    end else if (cfg_wr) begin
      if (cfg_idx == aqpc_pkg::REG_SAMPLE_RATE) rate_r <= pwdata[aqpc_pkg::RATE_W-1:0];
      if (cfg_idx == aqpc_pkg::REG_LOOP) loop_r <= pwdata[0];
      if (cfg_idx == aqpc_pkg::REG_BCOUNT) bcnt_r <= pwdata[aqpc_pkg::BCNT_W-1:0];
      for (int j = 0; j < QUEUE_DEPTH; j++) begin
        if (cfg_idx == aqpc_pkg::REG_SIZE_A + 3'(j)) size_r[j] <= pwdata[SizeW-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      aqpc_pkg::REG_SAMPLE_RATE: prdata[aqpc_pkg::RATE_W-1:0] = rate_r;
      aqpc_pkg::REG_LOOP:        prdata[0] = loop_r;
      aqpc_pkg::REG_BCOUNT:      prdata[aqpc_pkg::BCNT_W-1:0] = bcnt_r;
      default: begin
        for (int j = 0; j < QUEUE_DEPTH; j++) begin
          if (cfg_idx == aqpc_pkg::REG_SIZE_A + 3'(j)) prdata[SizeW-1:0] = size_r[j];
        end
      end
    endcase
  end

  // A count above the queue depth is treated as the full depth.
  assign cnt_eff = (bcnt_r > 3'(QUEUE_DEPTH)) ? 3'(QUEUE_DEPTH) : bcnt_r;

  // One read port into the size table: the cursor entry while the room left
  // in it is measured, the scan entry otherwise. Entries past the count read 0.
  assign rd_i = (state_r == aqpc_pkg::S_AVAIL) ? idx_r : scan_i_r;
  always_comb begin
    sel_size = '0;
    for (int j = 0; j < QUEUE_DEPTH; j++) begin
      if ((rd_i == aqpc_pkg::IDX_W'(j)) && ({1'b0, rd_i} < cnt_eff)) begin
        sel_size[SizeW-1:0] = size_r[j];
      end
    end
  end

  assign idx_inc    = {1'b0, idx_r} + 1'b1;
  assign wrap_i     = wrap_mod(idx_inc, cnt_eff);
  assign walk_steps = (idx_inc < cnt_eff) ? cnt_eff - idx_inc : 3'd0;
  assign pos_steps  = ({1'b0, idx_r} < cnt_eff) ? {1'b0, idx_r} : cnt_eff;
  assign wraps      = loop_r && (op_r == aqpc_pkg::OP_ADVANCE);
  assign next_i     = (wraps && ({1'b0, scan_i_r} + 1'b1 == cnt_eff)) ? 3'd0
                                                                     : {1'b0, scan_i_r} + 1'b1;
  // A seek lands strictly inside an entry; an advance may land on its end.
  assign scan_hit   = (op_r == aqpc_pkg::OP_SEEK) ? (rest_r < {2'b0, sel_size})
                                                  : (rest_r <= {2'b0, sel_size});

  assign in_acc   = in_req.valid && in_req.ready;
  assign out_load = (state_r == aqpc_pkg::S_OUT) && (!out_valid_r || out_rsp.ready);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      aqpc_pkg::S_IDLE: begin
        if (in_acc) begin
          case (in_req.op)
            aqpc_pkg::OP_ADVANCE:
              state_nxt = (playing_r && cnt_eff != 3'd0) ? aqpc_pkg::S_SCALE
                                                         : aqpc_pkg::S_POS_INIT;
            aqpc_pkg::OP_SEEK: state_nxt = aqpc_pkg::S_TOT;
            default:           state_nxt = aqpc_pkg::S_POS_INIT;
          endcase
        end
      end
      aqpc_pkg::S_SCALE: if (scale_done) state_nxt = aqpc_pkg::S_ROUND;
      aqpc_pkg::S_ROUND: state_nxt = aqpc_pkg::S_SAT;
      aqpc_pkg::S_SAT:   state_nxt = aqpc_pkg::S_AVAIL;
      aqpc_pkg::S_AVAIL: state_nxt = aqpc_pkg::S_WALK;
      aqpc_pkg::S_WALK: begin
        if (avail_r >= n_r)  state_nxt = aqpc_pkg::S_POS_INIT;
        else if (loop_r)     state_nxt = aqpc_pkg::S_TOT;
        else                 state_nxt = aqpc_pkg::S_SCAN;
      end
      aqpc_pkg::S_TOT: begin
        if (steps_r == 3'd0) begin
          if (acc_r == '0)                           state_nxt = aqpc_pkg::S_POS_INIT;
          else if (loop_r)                           state_nxt = aqpc_pkg::S_MOD;
          else if (rest_r >= acc_r)                  state_nxt = aqpc_pkg::S_POS_INIT;
          else                                       state_nxt = aqpc_pkg::S_SCAN;
        end
      end
      aqpc_pkg::S_MOD:  if (rem_done) state_nxt = aqpc_pkg::S_SCAN;
      aqpc_pkg::S_SCAN: if (steps_r == 3'd0 || scan_hit) state_nxt = aqpc_pkg::S_POS_INIT;
      aqpc_pkg::S_POS_INIT: state_nxt = aqpc_pkg::S_POS;
      aqpc_pkg::S_POS:  if (steps_r == 3'd0) state_nxt = aqpc_pkg::S_OUT;
      aqpc_pkg::S_OUT:  if (out_load) state_nxt = aqpc_pkg::S_IDLE;
      default: state_nxt = aqpc_pkg::S_IDLE;
    endcase
  end

  // Datapath and unit controls.
  always_comb begin
    playing_nxt = playing_r;
    idx_nxt     = idx_r;
    off_nxt     = off_r;
    frac_nxt    = frac_r;
    op_nxt      = op_r;
    status_nxt  = status_r;
    adv_nxt     = adv_r;
    n_nxt       = n_r;
    rsum_nxt    = rsum_r;
    avail_nxt   = avail_r;
    rest_nxt    = rest_r;
    acc_nxt     = acc_r;
    scan_i_nxt  = scan_i_r;
    steps_nxt   = steps_r;
    scale_start = 1'b0;
    rem_start   = 1'b0;
    rem_dvd     = rest_r;
    case (state_r)
      aqpc_pkg::S_IDLE: begin
        if (in_acc) begin
          op_nxt     = in_req.op;
          status_nxt = aqpc_pkg::ST_DONE;
          adv_nxt    = '0;
          rest_nxt   = in_req.seek_target;
          acc_nxt    = '0;
          scan_i_nxt = '0;
          steps_nxt  = cnt_eff;
          case (in_req.op)
            aqpc_pkg::OP_ADVANCE: begin
              if (playing_r && cnt_eff != 3'd0) scale_start = 1'b1;
              else status_nxt = aqpc_pkg::ST_IGNORED;
            end
            aqpc_pkg::OP_SEEK: ;
            aqpc_pkg::OP_PLAY: begin
              idx_nxt     = '0;
              off_nxt     = '0;
              frac_nxt    = '0;
              playing_nxt = 1'b1;
            end
            default: status_nxt = aqpc_pkg::ST_IGNORED;
          endcase
        end
      end
      aqpc_pkg::S_SCALE: begin
        if (scale_done) begin
          n_nxt    = scale_quo;
          rsum_nxt = 32'(frac_r) + $signed({2'b0, scale_rem});
        end
      end
      aqpc_pkg::S_ROUND: begin
        // Round to nearest: a remainder of half a sample or more borrows one.
        if (rsum_r >= aqpc_pkg::HALF_NS) begin
          frac_nxt = aqpc_pkg::FRAC_W'(rsum_r - aqpc_pkg::NS_PER_S_S);
          n_nxt    = n_r + 1'b1;
        end else begin
          frac_nxt = aqpc_pkg::FRAC_W'(rsum_r);
        end
      end
      aqpc_pkg::S_SAT: begin
        if (n_r > aqpc_pkg::COUNT_MAX) n_nxt = aqpc_pkg::COUNT_MAX;
        adv_nxt = (n_r > aqpc_pkg::COUNT_MAX) ? aqpc_pkg::COUNT_MAX[aqpc_pkg::ADV_W-1:0]
                                              : n_r[aqpc_pkg::ADV_W-1:0];
      end
      aqpc_pkg::S_AVAIL: begin
        avail_nxt = (off_r < sel_size) ? sel_size - off_r : '0;
      end
      aqpc_pkg::S_WALK: begin
        if (avail_r >= n_r) begin
          off_nxt = off_r + n_r;
        end else begin
          rest_nxt   = aqpc_pkg::POS_W'(n_r - avail_r);
          acc_nxt    = '0;
          scan_i_nxt = loop_r ? '0 : idx_inc[aqpc_pkg::IDX_W-1:0];
          steps_nxt  = loop_r ? cnt_eff : walk_steps;
        end
      end
      aqpc_pkg::S_TOT: begin
        if (steps_r != 3'd0) begin
          acc_nxt    = acc_r + {2'b0, sel_size};
          scan_i_nxt = scan_i_r + 1'b1;
          steps_nxt  = steps_r - 1'b1;
        end else if (acc_r == '0) begin
          if (op_r == aqpc_pkg::OP_SEEK) begin
            status_nxt = aqpc_pkg::ST_RANGE;
          end else begin
            // Looping over nothing but empty entries ends playback.
            idx_nxt     = '0;
            off_nxt     = '0;
            frac_nxt    = '0;
            playing_nxt = 1'b0;
            status_nxt  = aqpc_pkg::ST_END;
          end
        end else if (loop_r) begin
          // Whole turns of the queue are dropped before the walk.
          rem_start = 1'b1;
          rem_dvd   = (op_r == aqpc_pkg::OP_SEEK) ? rest_r : rest_r - 1'b1;
        end else if (rest_r >= acc_r) begin
          status_nxt = aqpc_pkg::ST_RANGE;
        end else begin
          scan_i_nxt = '0;
          steps_nxt  = cnt_eff;
        end
      end
      aqpc_pkg::S_MOD: begin
        if (rem_done) begin
          rest_nxt   = (op_r == aqpc_pkg::OP_SEEK) ? rem_q : rem_q + 1'b1;
          scan_i_nxt = (op_r == aqpc_pkg::OP_SEEK) ? '0 : wrap_i[aqpc_pkg::IDX_W-1:0];
          steps_nxt  = cnt_eff;
        end
      end
      aqpc_pkg::S_SCAN: begin
        if (steps_r == 3'd0) begin
          // Ran off the end of the queue: rewind and stop.
          idx_nxt     = '0;
          off_nxt     = '0;
          frac_nxt    = '0;
          playing_nxt = 1'b0;
          status_nxt  = aqpc_pkg::ST_END;
        end else if (scan_hit) begin
          idx_nxt = scan_i_r;
          off_nxt = rest_r[aqpc_pkg::OFF_W-1:0];
          if (op_r == aqpc_pkg::OP_SEEK) frac_nxt = '0;
        end else begin
          rest_nxt   = rest_r - {2'b0, sel_size};
          scan_i_nxt = next_i[aqpc_pkg::IDX_W-1:0];
          steps_nxt  = steps_r - 1'b1;
        end
      end
      aqpc_pkg::S_POS_INIT: begin
        acc_nxt    = {2'b0, off_r};
        scan_i_nxt = '0;
        steps_nxt  = pos_steps;
      end
      aqpc_pkg::S_POS: begin
        if (steps_r != 3'd0) begin
          acc_nxt    = acc_r + {2'b0, sel_size};
          scan_i_nxt = scan_i_r + 1'b1;
          steps_nxt  = steps_r - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) out_valid_nxt = 1'b1;
    else if (out_rsp.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= aqpc_pkg::S_IDLE;
      playing_r   <= 1'b0;
      idx_r       <= '0;
      off_r       <= '0;
      frac_r      <= '0;
      out_valid_r <= 1'b0;
      status_r    <= aqpc_pkg::ST_DONE;
      steps_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      playing_r   <= playing_nxt;
      idx_r       <= idx_nxt;
      off_r       <= off_nxt;
      frac_r      <= frac_nxt;
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
      steps_r     <= steps_nxt;
    end
    op_r     <= op_nxt;
    adv_r    <= adv_nxt;
    n_r      <= n_nxt;
    rsum_r   <= rsum_nxt;
    avail_r  <= avail_nxt;
    rest_r   <= rest_nxt;
    acc_r    <= acc_nxt;
    scan_i_r <= scan_i_nxt;
    if (out_load) begin
      o_status_r <= status_r;
      o_adv_r    <= adv_r;
      o_idx_r    <= idx_r;
      o_off_r    <= off_r;
      o_pos_r    <= acc_r;
      o_play_r   <= playing_r;
    end
  end

  aqpc_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .start (scale_start),
    .secs  (in_req.elapsed_seconds),
    .nsec  (in_req.elapsed_nanoseconds),
    .rate  (rate_r),
    .done  (scale_done),
    .quo   (scale_quo),
    .rem   (scale_rem)
  );

  aqpc_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (rem_dvd),
    .divisor  (acc_r),
    .done     (rem_done),
    .rem      (rem_q)
  );

  assign in_req.ready             = (state_r == aqpc_pkg::S_IDLE);
  assign out_rsp.valid            = out_valid_r;
  assign out_rsp.status           = o_status_r;
  assign out_rsp.samples_advanced = o_adv_r;
  assign out_rsp.buffer_index     = o_idx_r;
  assign out_rsp.buffer_offset    = o_off_r;
  assign out_rsp.total_position   = o_pos_r;
  assign out_rsp.playing          = o_play_r;

  // The conversion unit only reports back while the sequencer waits for it.
  `AQPC_ASSERT_IMPL(a_scale_done_in_scale, scale_done, state_r == aqpc_pkg::S_SCALE, "scale done outside wait")
  // Playback stops only through an end of queue.
  `AQPC_ASSERT_IMPL(a_stop_means_end, $fell(playing_r), status_r == aqpc_pkg::ST_END, "stopped without end status")
  // The reduced walk length stays below the queue total it was taken by.
  `AQPC_ASSERT_IMPL(a_rem_below_total, rem_done, rem_q < acc_r, "remainder not below queue total")

endmodule

// File: hdl/aqpc_scale.sv
// Bit-serial time to sample conversion: (secs*1e9 + nsec) * rate split into
// quotient and remainder by 1e9, one rate bit at a time. Uses aqpc_pkg.
module aqpc_scale (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [aqpc_pkg::SECS_W-1:0]  secs,
  input  logic [aqpc_pkg::NSEC_W-1:0]  nsec,
  input  logic [aqpc_pkg::RATE_W-1:0]  rate,
  output logic                         done,
  output logic [aqpc_pkg::Q_W-1:0]     quo,
  output logic [aqpc_pkg::NSEC_W-1:0]  rem
);

  localparam int CW = $clog2(aqpc_pkg::RATE_W + 1);

  logic busy_r, busy_nxt, prep_r, prep_nxt, phase_r, phase_nxt, done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [aqpc_pkg::SECS_W:0] s_r, s_nxt;
  logic [aqpc_pkg::NSEC_W-1:0] n_r, n_nxt;
  logic [aqpc_pkg::RATE_W-1:0] rs_r, rs_nxt;
  logic [aqpc_pkg::Q_W-1:0] q_r, q_nxt;
  logic [31:0] r_r, r_nxt;

  always_comb begin
    busy_nxt  = busy_r;
    prep_nxt  = prep_r;
    phase_nxt = phase_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    s_nxt     = s_r;
    n_nxt     = n_r;
    rs_nxt    = rs_r;
    q_nxt     = q_r;
    r_nxt     = r_r;
    if (start) begin
      s_nxt     = {1'b0, secs};
      n_nxt     = nsec;
      rs_nxt    = rate;
      q_nxt     = '0;
      r_nxt     = '0;
      busy_nxt  = 1'b1;
      prep_nxt  = 1'b1;
      phase_nxt = 1'b0;
      cnt_nxt   = CW'(aqpc_pkg::RATE_W);
    end else if (busy_r) begin
      if (prep_r) begin
        // A nanosecond field of a second or more carries into the seconds.
        if (n_r >= aqpc_pkg::NS_PER_S) begin
          n_nxt = n_r - aqpc_pkg::NS_PER_S;
          s_nxt = s_r + 1'b1;
        end
        prep_nxt = 1'b0;
      end else if (!phase_r) begin
        r_nxt = {r_r[30:0], 1'b0} + (rs_r[aqpc_pkg::RATE_W-1] ? {2'b0, n_r} : 32'd0);
        q_nxt = {q_r[aqpc_pkg::Q_W-2:0], 1'b0}
              + (rs_r[aqpc_pkg::RATE_W-1] ? aqpc_pkg::Q_W'(s_r) : '0);
        rs_nxt    = {rs_r[aqpc_pkg::RATE_W-2:0], 1'b0};
        phase_nxt = 1'b1;
      end else begin
        if (r_r >= aqpc_pkg::TWO_NS) begin
          r_nxt = r_r - aqpc_pkg::TWO_NS;
          q_nxt = q_r + 2'd2;
        end else if (r_r >= {2'b0, aqpc_pkg::NS_PER_S}) begin
          r_nxt = r_r - {2'b0, aqpc_pkg::NS_PER_S};
          q_nxt = q_r + 1'b1;
        end
        phase_nxt = 1'b0;
        cnt_nxt   = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      prep_r  <= 1'b0;
      phase_r <= 1'b0;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      busy_r  <= busy_nxt;
      prep_r  <= prep_nxt;
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
      cnt_r   <= cnt_nxt;
    end
    s_r  <= s_nxt;
    n_r  <= n_nxt;
    rs_r <= rs_nxt;
    q_r  <= q_nxt;
    r_r  <= r_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;
  assign rem  = r_r[aqpc_pkg::NSEC_W-1:0];

endmodule

// File: hdl/aqpc_rem.sv
// Restoring remainder unit, one dividend bit per cycle.
// Depends on aqpc_pkg for the operand width.
module aqpc_rem (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [aqpc_pkg::POS_W-1:0]  dividend,
  input  logic [aqpc_pkg::POS_W-1:0]  divisor,
  output logic                        done,
  output logic [aqpc_pkg::POS_W-1:0]  rem
);

  localparam int W  = aqpc_pkg::POS_W;
  localparam int CW = $clog2(W + 1);

  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0] dvd_r, dvd_nxt, dvs_r, dvs_nxt, rem_r, rem_nxt;
  logic [W:0] trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, dvd_r[W-1]};
    if (start) begin
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        trial = trial - {1'b0, dvs_r};
      end
      rem_nxt = trial[W-1:0];
      dvd_nxt = {dvd_r[W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
